// File: rtl/core/utf8_to_utf16_transcoder_macros.svh
// assertion helpers used by the checker file
`ifndef UTF8_TO_UTF16_TRANSCODER_MACROS_SVH
`define UTF8_TO_UTF16_TRANSCODER_MACROS_SVH

// clocked property, off while reset is asserted
`define U8U16_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// implication form built on the one above
`define U8U16_ASSERT_NEXT(label, ante, cons, msg) \
    `U8U16_ASSERT(label, (ante) |=> (cons), msg)

`endif

// File: rtl/core/u8u16_pkg.sv
package u8u16_pkg;

    localparam int BYTE_W  = 8;
    localparam int UNIT_W  = 16;
    localparam int CP_W    = 21;
    localparam int CAP_W   = 16;

    // result queue
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    localparam logic [CAP_W-1:0]  CAP_RESET = 16'd1024;
    localparam logic [CP_W-1:0]   BMP_LIMIT = 21'h10000;
    localparam logic [CP_W-1:0]   MAX_CP    = 21'h10FFFF;
    localparam logic [UNIT_W-1:0] SURR_HI   = 16'hD800;
    localparam logic [UNIT_W-1:0] SURR_LO   = 16'hDC00;
    localparam logic [UNIT_W-1:0] SURR_MASK = 16'hFC00;

    localparam logic [BYTE_W-1:0] CONT_MASK = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_CODE = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_CODE = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_CODE = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD4_CODE = 8'hF0;

    typedef struct packed {
        logic [UNIT_W-1:0] code;
        logic              term;
        logic              run_last;
    } t_unit;

endpackage

// File: rtl/core/utf8_to_utf16_transcoder.sv
// utf-8 to utf-16 transcoder
// input channel: one utf-8 byte per word (i_byte_in, i_last) on i_in_valid/o_in_ready
// output channel: one utf-16 unit per word (o_code_unit, o_is_terminator, o_run_last)
//   on o_out_valid/i_out_ready; o_run_last marks the final unit caused by a byte
// config channel: i_cfg_valid/o_cfg_ready/i_cfg_data writes the unit capacity
//   (terminator included); always ready, write only while the block is idle
// each accepted byte is decoded in the cycle it arrives and its 0 to 3 units
//   (a surrogate pair plus the terminator at most) land in a 4-entry result queue
// units of an accepted byte are registered into the queue and show on the output once the units ahead of them are taken
// throughput: one byte per cycle while the queue holds at most one unit, so a
//   byte stream giving one unit per byte runs at full rate; the output port
//   moves one unit per cycle, which bounds the rate for multi-unit bytes
// receiver stall: units wait in the queue; o_in_ready drops once two or more
//   units are queued, so nothing is lost
// a zero byte or a byte with i_last ends the string; later bytes are taken and
//   ignored until reset
// reset (i_rst_n low, synchronous): queue emptied, decoder state cleared,
//   capacity back to 1024 units
module utf8_to_utf16_transcoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // byte input
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [u8u16_pkg::BYTE_W-1:0]  i_byte_in,
    input  logic                          i_last,
    // unit output
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [u8u16_pkg::UNIT_W-1:0]  o_code_unit,
    output logic                          o_is_terminator,
    output logic                          o_run_last,
    // capacity register write
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [u8u16_pkg::CAP_W-1:0]   i_cfg_data
);
    import u8u16_pkg::*;

    // decoder state
    logic [1:0]        r_need, n_need;
    logic [CP_W-1:0]   r_part, n_part;
    logic [CAP_W-1:0]  r_written, n_written;
    logic              r_stop, n_stop;
    logic              r_ended, n_ended;
    logic [CAP_W-1:0]  r_cap;

    // result queue
    t_unit             r_q [Q_DEPTH];
    logic [Q_AW-1:0]   r_head, r_tail;
    logic [Q_AW:0]     r_count;

    // per-byte results
    t_unit             n_units [3];
    logic [1:0]        n_cnt;
    logic              emit;
    logic [CP_W-1:0]   emit_cp;
    logic [CP_W-1:0]   cp_off;
    logic              end_now;
    logic              is_cont;
    logic [CAP_W:0]    cap_ext;
    logic [CAP_W:0]    w_plus1;

    logic              accept;
    logic              pop;

    assign o_cfg_ready = 1'b1;
    // room for a full three-unit burst
    assign o_in_ready  = (r_count <= (Q_AW+1)'(1));
    assign accept      = i_in_valid & o_in_ready;
    assign o_out_valid = (r_count != '0);
    assign pop         = o_out_valid & i_out_ready;

    assign o_code_unit     = r_q[r_head].code;
    assign o_is_terminator = r_q[r_head].term;
    assign o_run_last      = r_q[r_head].run_last;

    assign is_cont = ((i_byte_in & CONT_MASK) == CONT_CODE);
    assign cap_ext = {1'b0, r_cap};
    assign w_plus1 = {1'b0, r_written} + (CAP_W+1)'(1);
    assign cp_off  = emit_cp - BMP_LIMIT;

    // byte decode, mirrors the stream semantics in one pass
    always_comb begin
        n_need    = r_need;
        n_part    = r_part;
        n_written = r_written;
        n_stop    = r_stop;
        n_ended   = r_ended;
        emit      = 1'b0;
        emit_cp   = '0;
        end_now   = 1'b0;
        n_cnt     = 2'd0;
        for (int i = 0; i < 3; i++) begin
            n_units[i] = '0;
        end

        if (!r_ended) begin
            if (i_byte_in == '0) begin
                end_now = 1'b1;
            end else begin
                if (!r_stop) begin
                    if (r_need != 2'd0 && is_cont) begin
                        // continuation: shift in six payload bits
                        n_part = {r_part[CP_W-7:0], i_byte_in[5:0]};
                        n_need = r_need - 2'd1;
                        if (r_need == 2'd1) begin
                            emit    = 1'b1;
                            emit_cp = n_part;
                            n_part  = '0;
                        end
                    end else begin
                        // any pending lead is dropped, byte handled afresh
                        n_need = 2'd0;
                        n_part = '0;
                        if (w_plus1 >= cap_ext) begin
                            n_stop = 1'b1;
                        end else if (!i_byte_in[7]) begin
                            emit    = 1'b1;
                            emit_cp = {{(CP_W-BYTE_W){1'b0}}, i_byte_in};
                        end else if ((i_byte_in & LEAD2_MASK) == LEAD2_CODE) begin
                            n_part = {{(CP_W-5){1'b0}}, i_byte_in[4:0]};
                            n_need = 2'd1;
                        end else if ((i_byte_in & LEAD3_MASK) == LEAD3_CODE) begin
                            n_part = {{(CP_W-4){1'b0}}, i_byte_in[3:0]};
                            n_need = 2'd2;
                        end else if ((i_byte_in & LEAD4_MASK) == LEAD4_CODE) begin
                            n_part = {{(CP_W-3){1'b0}}, i_byte_in[2:0]};
                            n_need = 2'd3;
                        end
                    end
                end
                end_now = i_last;
            end
        end

        // code point to one unit or a surrogate pair, within capacity; none above MAX_CP
        if (emit) begin
            if (emit_cp < BMP_LIMIT) begin
                if (w_plus1 < cap_ext) begin
                    n_units[0].code = emit_cp[UNIT_W-1:0];
                    n_cnt     = 2'd1;
                    n_written = r_written + CAP_W'(1);
                end else begin
                    n_stop = 1'b1;
                end
            end else if (emit_cp <= MAX_CP) begin
                if (w_plus1 + (CAP_W+1)'(1) < cap_ext) begin
                    n_units[0].code = SURR_HI | {6'b0, cp_off[19:10]};
                    n_units[1].code = SURR_LO | {6'b0, cp_off[9:0]};
                    n_cnt     = 2'd2;
                    n_written = r_written + CAP_W'(2);
                end else begin
                    n_stop = 1'b1;
                end
            end
            if ({1'b0, n_written} + (CAP_W+1)'(1) >= cap_ext) begin
                n_stop = 1'b1;
            end
        end

        // end of string: drop pending sequence, add terminator unless capacity is zero
        if (end_now) begin
            n_need  = 2'd0;
            n_part  = '0;
            n_ended = 1'b1;
            if (r_cap != '0) begin
                n_units[n_cnt].code = '0;
                n_units[n_cnt].term = 1'b1;
                n_cnt = n_cnt + 2'd1;
            end
        end

        if (n_cnt != 2'd0) begin
            n_units[n_cnt - 2'd1].run_last = 1'b1;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_need    <= '0;
            r_part    <= '0;
            r_written <= '0;
            r_stop    <= 1'b0;
            r_ended   <= 1'b0;
            r_cap     <= CAP_RESET;
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
            if (accept) begin
                r_need    <= n_need;
                r_part    <= n_part;
                r_written <= n_written;
                r_stop    <= n_stop;
                r_ended   <= n_ended;
                r_tail    <= r_tail + Q_AW'(n_cnt);
            end
            if (pop) begin
                r_head <= r_head + Q_AW'(1);
            end
            r_count <= r_count + (accept ? (Q_AW+1)'(n_cnt) : '0)
                               - (pop ? (Q_AW+1)'(1) : '0);
        end
    end

    // queue payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int i = 0; i < 3; i++) begin
                if (2'(i) < n_cnt) begin
                    r_q[r_tail + Q_AW'(i)] <= n_units[i];
                end
            end
        end
    end

endmodule

// File: rtl/core/u8u16_checker.sv
`include "utf8_to_utf16_transcoder_macros.svh"

module u8u16_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [u8u16_pkg::UNIT_W-1:0]  o_code_unit,
    input logic                          o_is_terminator,
    input logic                          o_run_last
);
    import u8u16_pkg::*;

    logic out_take;
    logic hi_surr;
    logic lo_surr;
    logic term_ok;
    logic pair_take;

    assign out_take  = o_out_valid & i_out_ready;
    assign hi_surr   = ((o_code_unit & SURR_MASK) == SURR_HI);
    assign lo_surr   = ((o_code_unit & SURR_MASK) == SURR_LO);
    assign term_ok   = (o_code_unit == '0) && o_run_last;
    assign pair_take = out_take && hi_surr && !o_run_last && !o_is_terminator;

    // output valid holds until the word is taken
    `U8U16_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid, "output word dropped")

    // terminator is zero and closes its byte's burst
    `U8U16_ASSERT(a_term_form, (o_out_valid && o_is_terminator) |-> term_ok, "bad terminator")

    // nothing follows a delivered terminator
    `U8U16_ASSERT_NEXT(a_term_final, out_take && o_is_terminator, !o_out_valid, "unit after terminator")

    // high surrogate from a pair is followed at once by its low half or the terminator
    `U8U16_ASSERT_NEXT(a_pair, pair_take, o_out_valid && (lo_surr || o_is_terminator), "broken pair")

endmodule

bind utf8_to_utf16_transcoder u8u16_checker u_u8u16_checker (.*);
